@@ src/fifo_with_min_max_query_unit_defines.svh @@
// Assertion macros used by the top-level file to check its own logic
`ifndef FIFO_WITH_MIN_MAX_QUERY_UNIT_DEFINES_SVH
`define FIFO_WITH_MIN_MAX_QUERY_UNIT_DEFINES_SVH

// Check that a condition implies another condition in the same cycle
`define FWMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another condition in the next cycle
`define FWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fwmm_pkg.sv @@
package fwmm_pkg;

    // Action codes of an input word
    localparam int unsigned ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // Width of the reported entry count
    localparam int unsigned COUNT_W = 5;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_init;
        logic scan_step;
        logic load_out;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic scan_last;
    } t_status;

endpackage

@@ src/fwmm_ram.sv @@
module fwmm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/fwmm_ctrl.sv @@
module fwmm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  fwmm_pkg::t_status i_status,
    output fwmm_pkg::t_cmd    o_cmd
);

    fwmm_pkg::t_state r_state, n_state;
    fwmm_pkg::t_cmd   cmd;
    logic             r_out_valid, n_out_valid;

    // Sequence one word: act, prepare, scan, drain, deliver (scan and drain skipped when empty)
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            fwmm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = fwmm_pkg::S_PREP;
                end
            end
            fwmm_pkg::S_PREP: begin
                cmd.scan_init = 1'b1;
                n_state = i_status.count_zero ? fwmm_pkg::S_DONE : fwmm_pkg::S_SCAN;
            end
            fwmm_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = fwmm_pkg::S_DRAIN;
                end
            end
            fwmm_pkg::S_DRAIN: begin
                n_state = fwmm_pkg::S_DONE;
            end
            fwmm_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = fwmm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwmm_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        n_out_valid = cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwmm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != fwmm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

@@ src/fwmm_datapath.sv @@
module fwmm_datapath #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fwmm_pkg::t_cmd                     i_cmd,
    output fwmm_pkg::t_status                  o_status,
    input  logic [fwmm_pkg::ACT_W-1:0]         i_action,
    input  logic signed [VALUE_WIDTH-1:0]      i_value,
    output logic signed [VALUE_WIDTH-1:0]      o_min_value,
    output logic signed [VALUE_WIDTH-1:0]      o_max_value,
    output logic [fwmm_pkg::COUNT_W-1:0]       o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_push_dropped
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [PTR_W-1:0] r_head, r_tail, r_rd_ptr;
    logic [CNT_W-1:0] r_count, r_left;
    logic             r_dropped, r_rd_valid, r_first;
    logic signed [VALUE_WIDTH-1:0] r_min, r_max;
    logic signed [VALUE_WIDTH-1:0] r_o_min, r_o_max;
    logic [fwmm_pkg::COUNT_W-1:0]  r_o_count;
    logic             r_o_empty, r_o_dropped;

    logic             push_ok, pop_ok, full;
    logic [VALUE_WIDTH-1:0]        rd_data;
    logic signed [VALUE_WIDTH-1:0] rd_value;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Decode the action of the accepted word
    assign full    = (r_count == CNT_FULL);
    assign push_ok = i_cmd.accept && (i_action == fwmm_pkg::ACT_PUSH) && !full;
    assign pop_ok  = i_cmd.accept && (i_action == fwmm_pkg::ACT_POP) && (r_count != '0);

    fwmm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push_ok),
        .i_wr_addr (r_tail),
        .i_wr_data (i_value),
        .i_rd_en   (i_cmd.scan_step),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign rd_value = $signed(rd_data);

    // Advance pointers and count, track the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_rd_ptr   <= '0;
            r_left     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (push_ok) begin
                r_tail  <= next_slot(r_tail);
                r_count <= r_count + CNT_ONE;
            end else if (pop_ok) begin
                r_head  <= next_slot(r_head);
                r_count <= r_count - CNT_ONE;
            end
            if (i_cmd.scan_init) begin
                r_rd_ptr <= r_head;
                r_left   <= r_count;
            end else if (i_cmd.scan_step) begin
                r_rd_ptr <= next_slot(r_rd_ptr);
                r_left   <= r_left - CNT_ONE;
            end
            r_rd_valid <= i_cmd.scan_step;
        end
    end

    // Record a refused push
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dropped <= (i_action == fwmm_pkg::ACT_PUSH) && full;
        end
    end

    // Fold each read word into the running minimum and maximum
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_min   <= '0;
            r_max   <= '0;
            r_first <= 1'b1;
        end else if (r_rd_valid) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_min <= rd_value;
                r_max <= rd_value;
            end else begin
                if (rd_value < r_min) begin
                    r_min <= rd_value;
                end
                if (rd_value > r_max) begin
                    r_max <= rd_value;
                end
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_min     <= r_min;
            r_o_max     <= r_max;
            r_o_count   <= fwmm_pkg::COUNT_W'(r_count);
            r_o_empty   <= (r_count == '0);
            r_o_dropped <= r_dropped;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = (r_left == CNT_ONE);

    assign o_min_value    = r_o_min;
    assign o_max_value    = r_o_max;
    assign o_entry_count  = r_o_count;
    assign o_is_empty     = r_o_empty;
    assign o_push_dropped = r_o_dropped;

endmodule

@@ src/fifo_with_min_max_query_unit.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_action, i_value
// result    out        o_out_valid / i_out_stall o_min_value, o_max_value, o_entry_count,
//                                                o_is_empty, o_push_dropped
//
// A result is offered once its word is accepted and the entries held after its action are
// scanned (the scan is skipped when the queue is left empty); the scan reads one
// entry per cycle through the single read port of the entry RAM. The next word can be taken
// in the cycle after the load.
// Synchronous active-low reset clears the pointers, the count and the controller; the
// entry RAM is not cleared. Input is stalled from acceptance until the result is loaded
// into the output register, which holds while the result side stalls.
`include "fifo_with_min_max_query_unit_defines.svh"

module fifo_with_min_max_query_unit #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fwmm_pkg::ACT_W-1:0]    i_action,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_min_value,
    output logic signed [VALUE_WIDTH-1:0] o_max_value,
    output logic [fwmm_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_is_empty,
    output logic                          o_push_dropped
);

    localparam logic [fwmm_pkg::COUNT_W-1:0] COUNT_FULL = fwmm_pkg::COUNT_W'(QUEUE_DEPTH);

    fwmm_pkg::t_cmd    cmd;
    fwmm_pkg::t_status status;

    fwmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fwmm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_push_dropped (o_push_dropped)
    );

    // An accepted word blocks the input in the next cycle
    `FWMM_ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n,
                      i_in_valid && !o_in_stall, o_in_stall,
                      "input not stalled after accept")

    // An empty queue reports zero extremes
    `FWMM_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n,
                      o_out_valid && o_is_empty,
                      (o_min_value == '0) && (o_max_value == '0),
                      "empty result with nonzero extremes")

    // Extremes of a nonempty queue are ordered
    `FWMM_ASSERT_SAME(a_min_le_max, i_clk, i_rst_n,
                      o_out_valid && !o_is_empty, o_min_value <= o_max_value,
                      "minimum above maximum")

    // A refused push only happens on a full queue
    `FWMM_ASSERT_SAME(a_drop_full, i_clk, i_rst_n,
                      o_out_valid && o_push_dropped, o_entry_count == COUNT_FULL,
                      "push dropped while not full")

endmodule
